// ===== hdl/sxl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types, codes and character classes for the source text lexer.
// ----------------------------------------------------------------------------
package sxl_pkg;

   // lexer modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_NUM   = 2'd2;
   localparam logic [1:0] MODE_OP    = 2'd3;

   // token kinds
   localparam logic [2:0] KIND_IDENT   = 3'd0;
   localparam logic [2:0] KIND_OP      = 3'd1;
   localparam logic [2:0] KIND_INT     = 3'd2;
   localparam logic [2:0] KIND_FLOAT   = 3'd3;
   localparam logic [2:0] KIND_NEWLINE = 3'd4;

   localparam logic [2:0] KW_NONE = 3'd0;
   localparam logic [2:0] KW_IF   = 3'd1;
   localparam logic [2:0] KW_ELSE = 3'd2;
   localparam logic [2:0] KW_LOOP = 3'd3;
   localparam logic [2:0] KW_DECL = 3'd4;

   localparam logic [1:0] TY_NONE = 2'd0;
   localparam logic [1:0] TY_INT  = 2'd1;
   localparam logic [1:0] TY_CHAR = 2'd2;
   localparam logic [1:0] TY_BOOL = 2'd3;

   // words packed first character in the low byte
   localparam logic [15:0] WORD_IF   = 16'h6669;
   localparam logic [31:0] WORD_ELSE = 32'h6573_6C65;
   localparam logic [31:0] WORD_LOOP = 32'h706F_6F6C;
   localparam logic [31:0] WORD_DECL = 32'h6C63_6564;
   localparam logic [23:0] WORD_INT  = 24'h74_6E69;
   localparam logic [31:0] WORD_CHAR = 32'h7261_6863;
   localparam logic [31:0] WORD_BOOL = 32'h6C6F_6F62;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  ident_count;
      logic [30:0] int_accum;
      logic [29:0] frac_accum;
      logic [3:0]  frac_count;
      logic [1:0]  dot_count;
      logic [15:0] op_pending;
      logic [1:0]  op_pending_len;
   } lex_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] ident_chars;
      logic [7:0]  ident_len;
      logic [2:0]  keyword;
      logic [1:0]  type_name;
      logic [23:0] op_chars;
      logic [30:0] int_part;
      logic [29:0] frac_value;
      logic [3:0]  frac_len;
      logic        last_result;
   } token_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_single_op(input logic [7:0] c);
      logic r;
      case (c)
         ";", ":", "~", "[", "]", "{", "}", "(", ")", "\\", ".", ",", "?": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_multi_op(input logic [7:0] c);
      logic r;
      case (c)
         "*", "/", "%", "^", "&", "|", "=", "!", "+", "<", ">", "-": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/source_text_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer
// Streaming maximal-munch lexer: one character per beat in, tokens out.
// ----------------------------------------------------------------------------
// Path: an accepted character is held in the input register; its tokens then
//   reach rsp_* via the four-entry token queue and its single-beat output.
// Throughput: one character per cycle while two queue slots are free; a
//   character that closes one token and yields another pushes two tokens.
// Reset: synchronous, active high; lexer returns to idle, queue empties.
// ----------------------------------------------------------------------------
module source_text_lexer import sxl_pkg::*; #(
   parameter int IDENT_CHARS = 8,
   parameter int FRAC_DIGITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   // character beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   // token beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [63:0] rsp_ident_chars,
   output logic [7:0]  rsp_ident_len,
   output logic [2:0]  rsp_keyword,
   output logic [1:0]  rsp_type_name,
   output logic [23:0] rsp_op_chars,
   output logic [30:0] rsp_int_part,
   output logic [29:0] rsp_frac_value,
   output logic [3:0]  rsp_frac_len,
   output logic        rsp_last_result
);

   // Input register: holds one character until the queue has room for the
   // worst case of two tokens.
   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_ch_ff;
   logic                      in_eot_ff;

   // Lexer state: mode, accumulators, pending operator, identifier bytes.
   lex_state_type             state_ff, state_in;
   logic [8*IDENT_CHARS-1:0]  ibuf_ff, ibuf_in;

   token_type                 tok0, tok1, out_tok;
   logic [1:0]                tok_n;
   logic [QCNT_W-1:0]         q_count;
   logic                      proc;
   logic                      pop;

   // The character is consumed only when two queue slots are free; the
   // decision uses registered count alone so stall never sees rsp_stall.
   assign proc        = in_valid_ff && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_stall   = in_valid_ff && !proc;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign pop         = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_eot_ff <= req_end_of_text;
      end
   end

   // lexer state advances once per consumed character
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         ibuf_ff  <= '0;
      end else if (proc) begin
         state_ff <= state_in;
         ibuf_ff  <= ibuf_in;
      end
   end

   sxl_lex_step #(
      .IDENT_CHARS (IDENT_CHARS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_step (
      .cur_state (state_ff),
      .cur_ibuf  (ibuf_ff),
      .ch        (in_ch_ff),
      .eot       (in_eot_ff),
      .nxt_state (state_in),
      .nxt_ibuf  (ibuf_in),
      .tok0      (tok0),
      .tok1      (tok1),
      .tok_n     (tok_n)
   );

   // tokens wait here so a stalled output blocks no character while two slots are free
   sxl_tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (proc ? tok_n : 2'd0),
      .push0     (tok0),
      .push1     (tok1),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_tok   (out_tok),
      .count     (q_count)
   );

   assign rsp_kind        = out_tok.kind;
   assign rsp_ident_chars = out_tok.ident_chars;
   assign rsp_ident_len   = out_tok.ident_len;
   assign rsp_keyword     = out_tok.keyword;
   assign rsp_type_name   = out_tok.type_name;
   assign rsp_op_chars    = out_tok.op_chars;
   assign rsp_int_part    = out_tok.int_part;
   assign rsp_frac_value  = out_tok.frac_value;
   assign rsp_frac_len    = out_tok.frac_len;
   assign rsp_last_result = out_tok.last_result;

`ifndef SYNTHESIS
   // the room check must keep the queue from overflowing
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("token queue overflow");

   // end of text always leaves the lexer idle
   a_eot_idle: assert property (@(posedge clock) disable iff (reset)
      (proc && in_eot_ff) |=> (state_ff.mode == MODE_IDLE))
      else $error("lexer not idle after end of text");

   // the final token pushed for a character carries the last flag
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (proc && (tok_n != 2'd0)) |->
         ((tok_n == 2'd2) ? tok1.last_result : tok0.last_result))
      else $error("last token of a character not flagged");
`endif

endmodule

// ===== hdl/sxl_lex_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_lex_step
// One character of lexing: ends the open token, starts or emits a new one,
// flushes at end of text. Up to two tokens per character.
// ----------------------------------------------------------------------------
module sxl_lex_step import sxl_pkg::*; #(
   parameter int IDENT_CHARS = 8,
   parameter int FRAC_DIGITS = 9
) (
   input  lex_state_type              cur_state,
   input  logic [8*IDENT_CHARS-1:0]   cur_ibuf,
   input  logic [7:0]                 ch,
   input  logic                       eot,
   output lex_state_type              nxt_state,
   output logic [8*IDENT_CHARS-1:0]   nxt_ibuf,
   output token_type                  tok0,
   output token_type                  tok1,
   output logic [1:0]                 tok_n
);

   function automatic lex_state_type num_feed(input lex_state_type s, input logic [7:0] c);
      lex_state_type r;
      logic [34:0]   iv;
      logic [33:0]   fv;
      r  = s;
      iv = {1'b0, s.int_accum, 3'b000} + {3'b000, s.int_accum, 1'b0} + {31'd0, c[3:0]};
      fv = {1'b0, s.frac_accum, 3'b000} + {3'b000, s.frac_accum, 1'b0} + {30'd0, c[3:0]};
      if (c == CH_DOT) begin
         if (s.dot_count != 2'd2) r.dot_count = s.dot_count + 2'd1;
      end else if (s.dot_count == 2'd0) begin
         r.int_accum = (iv > {4'd0, INT_SAT}) ? INT_SAT : iv[30:0];
      end else if ((s.dot_count == 2'd1) && (s.frac_count < 4'(FRAC_DIGITS))) begin
         r.frac_accum = fv[29:0];
         r.frac_count = s.frac_count + 4'd1;
      end
      return r;
   endfunction

   function automatic token_type ident_tok(input lex_state_type s,
                                           input logic [8*IDENT_CHARS-1:0] b);
      token_type t;
      t = '0;
      t.kind        = KIND_IDENT;
      t.ident_chars = 64'(b);
      t.ident_len   = s.ident_count;
      if ((s.ident_count == 8'd2) && (b[15:0] == WORD_IF))   t.keyword = KW_IF;
      if ((s.ident_count == 8'd4) && (b[31:0] == WORD_ELSE)) t.keyword = KW_ELSE;
      if ((s.ident_count == 8'd4) && (b[31:0] == WORD_LOOP)) t.keyword = KW_LOOP;
      if ((s.ident_count == 8'd4) && (b[31:0] == WORD_DECL)) t.keyword = KW_DECL;
      if ((s.ident_count == 8'd3) && (b[23:0] == WORD_INT))  t.type_name = TY_INT;
      if ((s.ident_count == 8'd4) && (b[31:0] == WORD_CHAR)) t.type_name = TY_CHAR;
      if ((s.ident_count == 8'd4) && (b[31:0] == WORD_BOOL)) t.type_name = TY_BOOL;
      return t;
   endfunction

   function automatic token_type num_tok(input lex_state_type s);
      token_type t;
      t = '0;
      t.int_part = s.int_accum;
      if (s.dot_count != 2'd0) begin
         t.kind       = KIND_FLOAT;
         t.frac_value = s.frac_accum;
         t.frac_len   = s.frac_count;
      end else begin
         t.kind = KIND_INT;
      end
      return t;
   endfunction

   function automatic token_type op_tok(input logic [23:0] chars);
      token_type t;
      t = '0;
      t.kind     = KIND_OP;
      t.op_chars = chars;
      return t;
   endfunction

   lex_state_type             sa, sb;
   logic [8*IDENT_CHARS-1:0]  ba, bb;
   logic                      refeed;
   logic                      a_emit, b_emit, c_emit;
   token_type                 a_tok, b_tok, c_tok, second;
   logic                      second_v;
   logic [7:0]                f;
   logic                      alnum;

   assign f     = cur_state.op_pending[7:0];
   assign alnum = is_alpha(ch) || is_digit(ch);

   always_comb begin
      sa     = cur_state;
      ba     = cur_ibuf;
      refeed = 1'b0;
      a_emit = 1'b0;
      a_tok  = '0;

      // close or extend the open token
      case (cur_state.mode)
         MODE_IDENT: begin
            if (alnum) begin
               for (int k = 0; k < IDENT_CHARS; k++) begin
                  if (cur_state.ident_count == 8'(k)) ba[8*k +: 8] = ch;
               end
               if (cur_state.ident_count != 8'd255)
                  sa.ident_count = cur_state.ident_count + 8'd1;
            end else begin
               a_emit  = 1'b1;
               a_tok   = ident_tok(cur_state, cur_ibuf);
               sa.mode = MODE_IDLE;
               refeed  = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit(ch) || (ch == CH_DOT)) begin
               sa = num_feed(cur_state, ch);
            end else begin
               a_emit  = 1'b1;
               a_tok   = num_tok(cur_state);
               sa.mode = MODE_IDLE;
               refeed  = 1'b1;
            end
         end
         MODE_OP: begin
            a_emit = 1'b1;
            if (cur_state.op_pending_len >= 2'd2) begin
               if (ch == CH_EQ) begin
                  a_tok = op_tok({CH_EQ, cur_state.op_pending});
               end else begin
                  a_tok  = op_tok({8'h00, cur_state.op_pending});
                  refeed = 1'b1;
               end
            end else if (ch == CH_EQ) begin
               a_tok = op_tok({8'h00, CH_EQ, f});
            end else if ((ch == f) && ((f == CH_LT) || (f == CH_GT))) begin
               // shift operator, may still take a trailing '='
               a_emit = 1'b0;
            end else if (((ch == f) && ((f == CH_PLUS) || (f == CH_MINUS))) ||
                         ((f == CH_MINUS) && (ch == CH_GT))) begin
               a_tok = op_tok({8'h00, ch, f});
            end else begin
               a_tok  = op_tok({16'h0000, f});
               refeed = 1'b1;
            end
            if (a_emit) begin
               sa.mode           = MODE_IDLE;
               sa.op_pending     = '0;
               sa.op_pending_len = '0;
            end else begin
               sa.op_pending     = {f, f};
               sa.op_pending_len = 2'd2;
            end
         end
         default: refeed = 1'b1;
      endcase

      // idle: start a token or emit a one-character one
      sb     = sa;
      bb     = ba;
      b_emit = 1'b0;
      b_tok  = '0;
      if (refeed) begin
         if (is_alpha(ch)) begin
            sb.mode        = MODE_IDENT;
            bb             = (8*IDENT_CHARS)'(ch);
            sb.ident_count = 8'd1;
         end else if (is_digit(ch)) begin
            sb.mode       = MODE_NUM;
            sb.int_accum  = {27'd0, ch[3:0]};
            sb.frac_accum = '0;
            sb.frac_count = '0;
            sb.dot_count  = '0;
         end else if (is_single_op(ch)) begin
            b_emit            = 1'b1;
            b_tok             = op_tok({16'h0000, ch});
            sb.op_pending     = '0;
            sb.op_pending_len = '0;
         end else if (is_multi_op(ch)) begin
            sb.mode           = MODE_OP;
            sb.op_pending     = {8'h00, ch};
            sb.op_pending_len = 2'd1;
         end else if (ch == CH_NL) begin
            b_emit     = 1'b1;
            b_tok      = '0;
            b_tok.kind = KIND_NEWLINE;
         end
      end

      // end of text flush
      nxt_state = sb;
      nxt_ibuf  = bb;
      c_emit    = 1'b0;
      c_tok     = '0;
      if (eot) begin
         case (sb.mode)
            MODE_IDENT: begin
               c_emit = 1'b1;
               c_tok  = ident_tok(sb, bb);
            end
            MODE_NUM: begin
               c_emit = 1'b1;
               c_tok  = num_tok(sb);
            end
            MODE_OP: begin
               c_emit = 1'b1;
               c_tok  = (sb.op_pending_len >= 2'd2) ? op_tok({8'h00, sb.op_pending})
                                                    : op_tok({16'h0000, sb.op_pending[7:0]});
               nxt_state.op_pending     = '0;
               nxt_state.op_pending_len = '0;
            end
            default: c_emit = 1'b0;
         endcase
         nxt_state.mode = MODE_IDLE;
      end

      // order the tokens, mark the final one
      second   = b_emit ? b_tok : c_tok;
      second_v = b_emit || c_emit;
      if (a_emit) begin
         tok0  = a_tok;
         tok1  = second;
         tok_n = second_v ? 2'd2 : 2'd1;
      end else begin
         tok0  = second;
         tok1  = '0;
         tok_n = second_v ? 2'd1 : 2'd0;
      end
      if (tok_n == 2'd2) tok1.last_result = 1'b1;
      else if (tok_n == 2'd1) tok0.last_result = 1'b1;
   end

endmodule

// ===== hdl/sxl_tok_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_tok_queue
// Small token queue: takes up to two beats per cycle, gives one when popped.
// ----------------------------------------------------------------------------
module sxl_tok_queue import sxl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  token_type         push0,
   input  token_type         push1,
   input  logic              pop,
   output logic              out_valid,
   output token_type         out_tok,
   output logic [QCNT_W-1:0] count
);

   token_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   tail_nx;

   assign tail_nx   = tail_ff + QPTR_W'(1);
   assign head_in   = pop ? head_ff + QPTR_W'(1) : head_ff;
   assign tail_in   = tail_ff + QPTR_W'(push_n);
   assign count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   assign out_valid = (count_ff != '0);
   assign out_tok   = entry_ff[head_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) entry_ff[tail_ff] <= push0;
      if (push_n == 2'd2) entry_ff[tail_nx] <= push1;
   end

endmodule
